### rtl/mlfd_pkg.sv
package mlfd_pkg;

	// Header layout: 16 bytes, big-endian.
	localparam int unsigned HdrBytes = 16;
	localparam int unsigned HdrIdxW  = $clog2(HdrBytes);

	localparam logic [HdrIdxW-1:0] HdrMagicEnd = HdrIdxW'(4);
	localparam logic [HdrIdxW-1:0] HdrTypeHi   = HdrIdxW'(6);
	localparam logic [HdrIdxW-1:0] HdrTypeLo   = HdrIdxW'(7);
	localparam logic [HdrIdxW-1:0] HdrLenFirst = HdrIdxW'(8);
	localparam logic [HdrIdxW-1:0] HdrLast     = HdrIdxW'(HdrBytes - 1);

	// Magic word in force after reset.
	localparam logic [31:0] MagicReset = 32'h4E42_4C41;

	// Kind of a result item.
	typedef enum logic [1:0] {
		EvPayload  = 2'd0,
		EvEmpty    = 2'd1,
		EvBadMagic = 2'd2
	} event_kind_t;

	// One result item.
	typedef struct packed {
		event_kind_t kind;
		logic [7:0]  payload;
		logic [15:0] ptype;
		logic        last;
	} result_t;

endpackage

### rtl/magic_length_frame_deframer_unit.sv
// A result item is registered when its input byte is accepted, in the result register
// or, while the output stalls, in the skid register. Throughput: one byte per cycle while
// the skid register is empty; the header state, a 64-bit decrement and the magic compare
// all settle between the state registers and the result register. A two-entry output
// buffer (result register plus skid register) takes one more item in an output stall.
// Asynchronous reset (arst_n low) returns to header parsing, magic register at 0x4E424C41.
module magic_length_frame_deframer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  event_kind,
	output logic [7:0]  payload_byte,
	output logic [15:0] packet_type,
	output logic        last_of_packet,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);

	typedef enum logic [1:0] {
		PhHeader  = 2'd0,
		PhPayload = 2'd1,
		PhStopped = 2'd2
	} phase_t;

	phase_t                            phase_q, phase_d;
	logic [mlfd_pkg::HdrIdxW-1:0]      hdr_idx_q, hdr_idx_d;
	logic [31:0]                       magic_q, magic_d;
	logic [15:0]                       type_q, type_d;
	logic [63:0]                       left_q, left_d;
	logic [31:0]                       expected_q;

	mlfd_pkg::result_t                 res;
	logic                              res_valid;
	logic                              in_fire;

	mlfd_pkg::result_t                 out_q;
	logic                              out_valid_q;
	mlfd_pkg::result_t                 skid_q;
	logic                              skid_valid_q;

	assign in_ready  = !skid_valid_q;
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_q <= mlfd_pkg::MagicReset;
		end else if (cfg_valid && cfg_ready) begin
			expected_q <= cfg_data;
		end
	end

	// Header parsing, payload counting and result formation for one byte.
	always_comb begin
		phase_d   = phase_q;
		hdr_idx_d = hdr_idx_q;
		magic_d   = magic_q;
		type_d    = type_q;
		left_d    = left_q;
		res_valid = 1'b0;
		res       = '{kind: mlfd_pkg::EvPayload, payload: 8'd0, ptype: type_q, last: 1'b0};
		case (phase_q)
			PhHeader: begin
				if (hdr_idx_q < mlfd_pkg::HdrMagicEnd) begin
					magic_d = {magic_q[23:0], data_byte};
				end else if (hdr_idx_q inside {mlfd_pkg::HdrTypeHi, mlfd_pkg::HdrTypeLo}) begin
					type_d = {type_q[7:0], data_byte};
				end else if (hdr_idx_q >= mlfd_pkg::HdrLenFirst) begin
					left_d = {left_q[55:0], data_byte};
				end
				if (hdr_idx_q != mlfd_pkg::HdrLast) begin
					hdr_idx_d = hdr_idx_q + 1'b1;
				end else begin
					hdr_idx_d = '0;
					if (magic_q != expected_q) begin
						phase_d   = PhStopped;
						res_valid = 1'b1;
						res.kind  = mlfd_pkg::EvBadMagic;
					end else if (left_d == 64'd0) begin
						res_valid = 1'b1;
						res.kind  = mlfd_pkg::EvEmpty;
						res.last  = 1'b1;
					end else begin
						phase_d = PhPayload;
					end
				end
			end
			PhPayload: begin
				res_valid   = 1'b1;
				res.payload = data_byte;
				res.last    = (left_q == 64'd1);
				left_d      = left_q - 64'd1;
				if (left_q == 64'd1) begin
					phase_d   = PhHeader;
					hdr_idx_d = '0;
				end
			end
			default: begin
				// Stopped: every byte is dropped until reset.
			end
		endcase
	end

	// Parser state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PhHeader;
			hdr_idx_q <= '0;
			magic_q   <= '0;
			type_q    <= '0;
			left_q    <= '0;
		end else if (in_fire) begin
			phase_q   <= phase_d;
			hdr_idx_q <= hdr_idx_d;
			magic_q   <= magic_d;
			type_q    <= type_d;
			left_q    <= left_d;
		end
	end

	// Output buffer: result register with a skid entry behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_ready) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= in_fire && res_valid;
		end else if (in_fire && res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_ready) begin
				out_q <= skid_q;
			end
		end else if (!out_valid_q || out_ready) begin
			out_q <= res;
		end else begin
			skid_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign event_kind     = out_q.kind;
	assign payload_byte   = out_q.payload;
	assign packet_type    = out_q.ptype;
	assign last_of_packet = out_q.last;

`ifndef SYNTHESIS
	// The skid entry is only ever filled behind a waiting result.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry holds an item while the result register is empty");

	// Only payload items carry a nonzero byte.
	a_payload_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.kind != mlfd_pkg::EvPayload) |-> out_q.payload == 8'd0)
		else $error("non-payload item carries a payload byte");

	// Once stopped, the parser stays stopped until reset.
	a_stop_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PhStopped |=> phase_q == PhStopped)
		else $error("parser left the stopped phase without reset");

	// A bad-magic result always stops the parser.
	a_bad_magic_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && res_valid && res.kind == mlfd_pkg::EvBadMagic) |=> phase_q == PhStopped)
		else $error("bad magic reported without stopping");
`endif

endmodule

### bench/tb_magic_length_frame_deframer_unit.sv
module tb_magic_length_frame_deframer_unit;

	// Parser position inside the byte stream.
	typedef enum logic [1:0] {
		InHeader  = 2'd0,
		InPayload = 2'd1,
		Halted    = 2'd2
	} parse_phase_t;

	localparam int IdleLimit   = 2000;
	localparam int LongHold    = 300;
	localparam int HoldTrigger = 400;

	// Tracks the deframer state and holds the result items still to come.
	class frame_scoreboard;
		logic [31:0]                  magic_word = mlfd_pkg::MagicReset;
		parse_phase_t                 phase      = InHeader;
		logic [mlfd_pkg::HdrIdxW-1:0] hdr_count  = '0;
		logic [31:0]                  magic_acc  = '0;
		logic [15:0]                  type_acc   = '0;
		logic [63:0]                  remaining  = '0;
		mlfd_pkg::result_t            expected_q[$];
		int                           n_errors   = 0;
		int                           n_checked  = 0;
		int                           n_payload  = 0;
		int                           n_empty    = 0;
		int                           n_bad      = 0;

		function void set_magic(logic [31:0] v);
			magic_word = v;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void expect_item(mlfd_pkg::event_kind_t kind, logic [7:0] pb, logic last);
			mlfd_pkg::result_t r;
			r.kind    = kind;
			r.payload = pb;
			r.ptype   = type_acc;
			r.last    = last;
			expected_q.push_back(r);
		endfunction

		// Advance the parser by one accepted byte.
		function void note_input(logic [7:0] b);
			case (phase)
				InHeader: begin
					if (hdr_count < mlfd_pkg::HdrMagicEnd)
						magic_acc = {magic_acc[23:0], b};
					else if (hdr_count == mlfd_pkg::HdrTypeHi ||
							hdr_count == mlfd_pkg::HdrTypeLo)
						type_acc = {type_acc[7:0], b};
					else if (hdr_count >= mlfd_pkg::HdrLenFirst)
						remaining = {remaining[55:0], b};

					if (hdr_count != mlfd_pkg::HdrLast) begin
						hdr_count = hdr_count + 1'b1;
					end else begin
						hdr_count = '0;
						if (magic_acc != magic_word) begin
							phase = Halted;
							expect_item(mlfd_pkg::EvBadMagic, 8'h00, 1'b0);
						end else if (remaining == 64'd0) begin
							expect_item(mlfd_pkg::EvEmpty, 8'h00, 1'b1);
						end else begin
							phase = InPayload;
						end
					end
				end
				InPayload: begin
					expect_item(mlfd_pkg::EvPayload, b, remaining == 64'd1);
					remaining = remaining - 64'd1;
					if (remaining == 64'd0) begin
						phase     = InHeader;
						hdr_count = '0;
					end
				end
				default: begin
					// A halted parser ignores everything until reset.
				end
			endcase
		endfunction

		// Compare one accepted result item with the oldest expectation.
		function void check_result(logic [1:0] kind, logic [7:0] pb, logic [15:0] pt,
				logic last);
			mlfd_pkg::result_t e;
			n_checked++;
			if (expected_q.size() == 0) begin
				$error("Result item with no expectation: kind %0d byte %0h type %0h last %0d",
					kind, pb, pt, last);
				n_errors++;
				return;
			end
			e = expected_q.pop_front();
			case (e.kind)
				mlfd_pkg::EvPayload: n_payload++;
				mlfd_pkg::EvEmpty:   n_empty++;
				default:             n_bad++;
			endcase
			if (kind !== e.kind) begin
				$error("event_kind: expected %0d, actual %0d", e.kind, kind);
				n_errors++;
			end
			if (pb !== e.payload) begin
				$error("payload_byte: expected %0h, actual %0h", e.payload, pb);
				n_errors++;
			end
			if (pt !== e.ptype) begin
				$error("packet_type: expected %0h, actual %0h", e.ptype, pt);
				n_errors++;
			end
			if (last !== e.last) begin
				$error("last_of_packet: expected %0d, actual %0d", e.last, last);
				n_errors++;
			end
		endfunction

		function void report_leftover();
			if (expected_q.size() != 0) begin
				$error("%0d expected result items never arrived", expected_q.size());
				n_errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  event_kind;
	logic [7:0]  payload_byte;
	logic [15:0] packet_type;
	logic        last_of_packet;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] cfg_data;

	frame_scoreboard sb = new;
	logic [31:0]     cur_magic;
	int              n_sent = 0;
	int              n_cfg  = 0;
	int              idle_cycles = 0;
	bit              hold_done = 1'b0;

	magic_length_frame_deframer_unit DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.data_byte      (data_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.event_kind     (event_kind),
		.payload_byte   (payload_byte),
		.packet_type    (packet_type),
		.last_of_packet (last_of_packet),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data)
	);

	always #5 clk = ~clk;

	// Mostly short gaps, now and then a long one.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	// Offer one byte, wait for its acceptance, then idle for gap cycles.
	task automatic send_byte(input logic [7:0] b, input int gap);
		@(negedge clk);
		in_valid  <= 1'b1;
		data_byte <= b;
		do @(posedge clk); while (!in_ready);
		sb.note_input(b);
		n_sent++;
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Stop offering and wait until every expected result item has come out.
	task automatic pause_until_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_magic(input logic [31:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		sb.set_magic(v);
		cur_magic = v;
		n_cfg++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Send one frame; when cfg_at names a header byte, rewrite the magic right after it.
	task automatic send_frame(input logic [31:0] magic, input logic [15:0] ver,
			input logic [15:0] ptype, input logic [63:0] len, input int cfg_at,
			input logic [31:0] cfg_val, input bit steady, input bit corner_fill);
		logic [127:0] hdr_word;
		logic [7:0]   pb;
		hdr_word = {magic, ver, ptype, len};
		for (int i = 0; i < mlfd_pkg::HdrBytes; i++) begin
			send_byte(hdr_word[127 - 8 * i -: 8], steady ? 0 : idle_len());
			if (i == cfg_at) begin
				pause_until_drained();
				write_magic(cfg_val);
			end
		end
		for (logic [63:0] k = 64'd0; k < len; k++) begin
			if (corner_fill)
				pb = k[0] ? 8'hFF : 8'h00;
			else
				pb = 8'($urandom_range(0, 255));
			send_byte(pb, steady ? 0 : idle_len());
		end
	endtask

	// Receiver: random ready runs and stalls, plus one long hold-off.
	initial begin
		int run;
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!hold_done && sb.n_checked >= HoldTrigger) begin
				hold_done = 1'b1;
				@(negedge clk);
				out_ready <= 1'b0;
				repeat (LongHold - 1) @(negedge clk);
			end
			if ($urandom_range(0, 4) == 0)
				run = $urandom_range(50, 150);
			else
				run = $urandom_range(1, 8);
			@(negedge clk);
			out_ready <= 1'b1;
			repeat (run - 1) @(negedge clk);
			stall = idle_len();
			if (stall > 0) begin
				@(negedge clk);
				out_ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
		end
	end

	// Result monitor.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(event_kind, payload_byte, packet_type, last_of_packet);
	end

	// Watchdog on cycles without any accepted item.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IdleLimit) begin
				$display("Timeout after %0d cycles with no accepted item", IdleLimit);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// Stimulus.
	initial begin
		logic [31:0] m;
		logic [31:0] fm;
		logic [63:0] len;
		logic [15:0] ptype;
		int          quota;
		int          r;
		int          cfg_at;
		int          wait_cycles;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		data_byte = 8'h00;
		cfg_valid = 1'b0;
		cfg_data  = 32'h0;
		cur_magic = mlfd_pkg::MagicReset;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// Empty packet under the reset magic, all-ones version and type.
		send_frame(mlfd_pkg::MagicReset, 16'hFFFF, 16'hFFFF, 64'd0, -1, 32'h0, 1'b1, 1'b0);

		// The magic is rewritten in the middle of a header; the new value must decide.
		pause_until_drained();
		write_magic(32'h1234_5678);
		send_frame(32'hCAFE_F00D, 16'h0000, 16'h0000, 64'd2, 5, 32'hCAFE_F00D, 1'b0, 1'b1);

		// Random frames under several magic settings, extremes among them.
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0:       m = 32'h0000_0000;
				1:       m = 32'hFFFF_FFFF;
				3:       m = mlfd_pkg::MagicReset;
				5:       m = 32'hA5A5_5A5A;
				default: m = $urandom;
			endcase
			pause_until_drained();
			write_magic(m);
			quota = n_sent + 210;
			while (n_sent < quota) begin
				r = $urandom_range(0, 99);
				if (r < 15)
					len = 64'd0;
				else if (r < 65)
					len = 64'($urandom_range(1, 8));
				else if (r < 90)
					len = 64'($urandom_range(9, 24));
				else if (r < 98)
					len = 64'($urandom_range(25, 64));
				else
					len = 64'($urandom_range(256, 300));
				r = $urandom_range(0, 9);
				if (r == 0)
					ptype = 16'h0000;
				else if (r == 1)
					ptype = 16'hFFFF;
				else
					ptype = 16'($urandom);
				fm     = cur_magic;
				cfg_at = -1;
				if ($urandom_range(0, 9) == 0) begin
					cfg_at = $urandom_range(0, mlfd_pkg::HdrBytes - 2);
					fm     = $urandom;
				end
				send_frame(fm, 16'($urandom), ptype, len, cfg_at, fm,
					$urandom_range(0, 3) == 0, 1'b0);
			end
		end

		// A bad magic halts the parser for good, so it comes last, followed by noise.
		send_frame(~cur_magic, 16'($urandom), 16'($urandom), 64'd3, -1, 32'h0, 1'b0, 1'b0);
		repeat (30) send_byte(8'($urandom_range(0, 255)), idle_len());
		send_frame(cur_magic, 16'($urandom), 16'($urandom), 64'd4, -1, 32'h0, 1'b0, 1'b0);
		@(negedge clk);
		in_valid <= 1'b0;

		// Drain, then give the block time to show any stray result.
		wait_cycles = 0;
		while (sb.pending() != 0 && wait_cycles < 4 * IdleLimit) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (20) @(posedge clk);
		sb.report_leftover();

		$display("Sent %0d bytes over %0d magic writes; %0d result items checked.",
			n_sent, n_cfg, sb.n_checked);
		$display("Seen %0d payload bytes, %0d empty packets, %0d bad-magic halts; %0d errors.",
			sb.n_payload, sb.n_empty, sb.n_bad, sb.n_errors);
		if (sb.n_errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
